### sv/acbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_pkg: shared types and constants of the buzzer sequencer
// widths, register indexes, reset values and the structs passed between modules
// ----------------------------------------------------------------------------
package acbs_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_DURATION = 3'd0,
    REG_BEEP_ON        = 3'd1,
    REG_BEEP_OFF       = 3'd2,
    REG_CLICK_LENGTH   = 3'd3,
    REG_CLICK_GAP      = 3'd4,
    REG_ALARM_TONE     = 3'd5,
    REG_CLICK_TONE     = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLICK  = 1'b1
  } op_e;

  localparam logic [DUR_W-1:0]  RST_ALARM_DURATION = 24'd20000;
  localparam logic [MS_W-1:0]   RST_BEEP_ON        = 16'd400;
  localparam logic [MS_W-1:0]   RST_BEEP_OFF       = 16'd200;
  localparam logic [MS_W-1:0]   RST_CLICK_LENGTH   = 16'd18;
  localparam logic [MS_W-1:0]   RST_CLICK_GAP      = 16'd35;
  localparam logic [FREQ_W-1:0] RST_ALARM_TONE     = 16'd1000;
  localparam logic [FREQ_W-1:0] RST_CLICK_TONE     = 16'd1800;

  typedef struct packed {
    logic [DUR_W-1:0]  alarm_duration_ms;
    logic [MS_W-1:0]   beep_on_ms;
    logic [MS_W-1:0]   beep_off_ms;
    logic [MS_W-1:0]   click_length_ms;
    logic [MS_W-1:0]   click_gap_ms;
    logic [FREQ_W-1:0] alarm_tone_hz;
    logic [FREQ_W-1:0] click_tone_hz;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_ms;
    logic              countdown_done;
  } item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_hz;
    logic              alarm_running;
    logic              click_running;
    logic              request_taken;
  } result_t;

  typedef struct packed {
    logic              tone_on;
    logic [FREQ_W-1:0] current_tone;
    logic              alarm_active;
    logic [TIME_W-1:0] alarm_start_time;
    logic [TIME_W-1:0] phase_start_time;
    logic              click_active;
    logic [TIME_W-1:0] click_start_time;
    logic [TIME_W-1:0] last_click_time;
    logic              previous_done;
  } seq_state_t;

endpackage
`default_nettype wire

### sv/acbs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_in_if: input channel of the buzzer sequencer
// valid/ready handshake carrying one update or click beat
// ----------------------------------------------------------------------------
interface acbs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [acbs_pkg::TIME_W-1:0] now_ms;
  logic                      countdown_done;

  modport source (output valid, output op, output now_ms, output countdown_done,
                  input ready);
  modport sink (input valid, input op, input now_ms, input countdown_done,
                output ready);
endinterface
`default_nettype wire

### sv/acbs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_out_if: result channel of the buzzer sequencer
// valid/ready handshake carrying one result beat
// ----------------------------------------------------------------------------
interface acbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [acbs_pkg::FREQ_W-1:0] tone_hz;
  logic                        alarm_running;
  logic                        click_running;
  logic                        request_taken;

  modport source (output valid, output tone_hz, output alarm_running,
                  output click_running, output request_taken, input ready);
  modport sink (input valid, input tone_hz, input alarm_running,
                input click_running, input request_taken, output ready);
endinterface
`default_nettype wire

### sv/alarm_and_click_buzzer_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_and_click_buzzer_sequencer_core: buzzer tone sequencer top level
// input register, one-pass sequencing logic and a result register
// ----------------------------------------------------------------------------
// an accepted input beat passes through the input register and the result register, in that order
// throughput: one beat per cycle while the result channel is not stalled, set by the state update loop
// while a result beat waits, the input register still takes one more beat
// reset: asynchronous, active low; state cleared, registers back to defaults,
// both channels empty
module alarm_and_click_buzzer_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acbs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  acbs_in_if.sink                         in_if,
  acbs_out_if.source                      out_if
);
  import acbs_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item_q;
  logic    s1_valid_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t seq_res;
  logic    out_free;
  logic    advance;
  logic    in_take;

  // timing and tone registers
  acbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // result register empties or drains this cycle
  assign out_free = !out_valid_q || out_if.ready;
  // input register hands its beat to the sequencer
  assign advance  = s1_valid_q && out_free;
  // input register has room for a new beat
  assign in_if.ready = !s1_valid_q || advance;
  assign in_take     = in_if.valid && in_if.ready;

  assign in_item.op             = in_if.op;
  assign in_item.now_ms         = in_if.now_ms;
  assign in_item.countdown_done = in_if.countdown_done;

  // state update happens exactly when the beat moves into the result register
  acbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (seq_res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_take;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_res_q <= seq_res;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.tone_hz       = out_res_q.tone_hz;
  assign out_if.alarm_running = out_res_q.alarm_running;
  assign out_if.click_running = out_res_q.click_running;
  assign out_if.request_taken = out_res_q.request_taken;

endmodule
`default_nettype wire

### sv/acbs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_cfg_regs: configuration register file
// seven write-only timing and tone registers, unknown indexes are dropped
// ----------------------------------------------------------------------------
module acbs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [acbs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [acbs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output acbs_pkg::cfg_t                      cfg_o
);
  import acbs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ALARM_DURATION: cfg_d.alarm_duration_ms = cfg_wdata_i[DUR_W-1:0];
        REG_BEEP_ON:        cfg_d.beep_on_ms        = cfg_wdata_i[MS_W-1:0];
        REG_BEEP_OFF:       cfg_d.beep_off_ms       = cfg_wdata_i[MS_W-1:0];
        REG_CLICK_LENGTH:   cfg_d.click_length_ms   = cfg_wdata_i[MS_W-1:0];
        REG_CLICK_GAP:      cfg_d.click_gap_ms      = cfg_wdata_i[MS_W-1:0];
        REG_ALARM_TONE:     cfg_d.alarm_tone_hz     = cfg_wdata_i[FREQ_W-1:0];
        REG_CLICK_TONE:     cfg_d.click_tone_hz     = cfg_wdata_i[FREQ_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_duration_ms <= RST_ALARM_DURATION;
      cfg_q.beep_on_ms        <= RST_BEEP_ON;
      cfg_q.beep_off_ms       <= RST_BEEP_OFF;
      cfg_q.click_length_ms   <= RST_CLICK_LENGTH;
      cfg_q.click_gap_ms      <= RST_CLICK_GAP;
      cfg_q.alarm_tone_hz     <= RST_ALARM_TONE;
      cfg_q.click_tone_hz     <= RST_CLICK_TONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/acbs_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_seq: alarm and click sequencing state
// holds the sequencer state and works out one beat's update in one pass
// ----------------------------------------------------------------------------
module acbs_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  acbs_pkg::item_t     item_i,
  input  acbs_pkg::cfg_t      cfg_i,
  output acbs_pkg::result_t   result_o
);
  import acbs_pkg::*;

  seq_state_t state_q, state_d;
  logic       taken;

  always_comb begin
    logic [TIME_W-1:0] now;
    logic              done;
    logic [MS_W-1:0]   phase_len;
    now       = item_i.now_ms;
    done      = item_i.countdown_done;
    phase_len = '0;
    state_d   = state_q;
    taken     = 1'b0;

    if (op_e'(item_i.op) == OP_CLICK) begin
      // refused during alarm, while done, or inside the gap
      if (!state_q.alarm_active && !done &&
          (now - state_q.last_click_time) >= TIME_W'(cfg_i.click_gap_ms)) begin
        taken                    = 1'b1;
        state_d.last_click_time  = now;
        state_d.click_start_time = now;
        state_d.click_active     = 1'b1;
        state_d.current_tone     = cfg_i.click_tone_hz;
        state_d.tone_on          = (cfg_i.click_tone_hz != '0);
      end
    end else begin
      // rising done flag starts the alarm
      if (done && !state_q.previous_done) begin
        state_d.click_active     = 1'b0;
        state_d.alarm_active     = 1'b1;
        state_d.alarm_start_time = now;
        state_d.phase_start_time = now;
        if (!state_d.tone_on) begin
          state_d.current_tone = cfg_i.alarm_tone_hz;
          state_d.tone_on      = 1'b1;
        end
      end
      state_d.previous_done = done;

      // flag dropped: stop the alarm
      if (!done && state_d.alarm_active) begin
        state_d.alarm_active     = 1'b0;
        state_d.alarm_start_time = '0;
        state_d.phase_start_time = '0;
        if (state_d.tone_on) begin
          state_d.current_tone = '0;
          state_d.tone_on      = 1'b0;
        end
      end

      if (state_d.alarm_active) begin
        if ((now - state_d.alarm_start_time) >= TIME_W'(cfg_i.alarm_duration_ms)) begin
          state_d.alarm_active     = 1'b0;
          state_d.alarm_start_time = '0;
          state_d.phase_start_time = '0;
          if (state_d.tone_on) begin
            state_d.current_tone = '0;
            state_d.tone_on      = 1'b0;
          end
        end else begin
          phase_len = state_d.tone_on ? cfg_i.beep_on_ms : cfg_i.beep_off_ms;
          if ((now - state_d.phase_start_time) >= TIME_W'(phase_len)) begin
            state_d.phase_start_time = now;
            state_d.current_tone     = state_d.tone_on ? '0 : cfg_i.alarm_tone_hz;
            state_d.tone_on          = !state_d.tone_on;
          end
        end
      end else if (state_d.click_active &&
                   (now - state_d.click_start_time) >= TIME_W'(cfg_i.click_length_ms)) begin
        state_d.click_active = 1'b0;
        if (state_d.tone_on) begin
          state_d.current_tone = '0;
          state_d.tone_on      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.tone_hz       = state_d.current_tone;
  assign result_o.alarm_running = state_d.alarm_active;
  assign result_o.click_running = state_d.click_active;
  assign result_o.request_taken = taken;

endmodule
`default_nettype wire

### tb/alarm_and_click_buzzer_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_and_click_buzzer_sequencer_core_tb: self-checking bench for the buzzer
// sequencer. It drives update and click beats with random gaps and back
// pressure, and predicts every result from its own model of the alarm and
// click timing. Each result is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module alarm_and_click_buzzer_sequencer_core_tb;
  import acbs_pkg::*;

  // write to an index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // generous bound: ~1170 beats plus random gaps, stalls and hold-offs
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_IDLE    = 11;
  localparam int unsigned RX_HOLD     = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  acbs_in_if  beat_in ();
  acbs_out_if beat_out ();

  alarm_and_click_buzzer_sequencer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (beat_in),
    .out_if      (beat_out)
  );

  // predictor state: register copy and sequencer state
  cfg_t       buzz_cfg;
  seq_state_t buzz_st;
  result_t    tone_results_q[$];

  // stimulus controls shared with the receiver process
  logic        tx_idle;
  logic        rx_idle;
  int unsigned rx_hold;
  logic [TIME_W-1:0] wall_ms;
  logic        countdown_flag;

  // run bookkeeping
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned settings_applied;
  int unsigned clicks_taken;
  int unsigned alarm_starts;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic void reset_predictor();
    buzz_cfg.alarm_duration_ms = RST_ALARM_DURATION;
    buzz_cfg.beep_on_ms        = RST_BEEP_ON;
    buzz_cfg.beep_off_ms       = RST_BEEP_OFF;
    buzz_cfg.click_length_ms   = RST_CLICK_LENGTH;
    buzz_cfg.click_gap_ms      = RST_CLICK_GAP;
    buzz_cfg.alarm_tone_hz     = RST_ALARM_TONE;
    buzz_cfg.click_tone_hz     = RST_CLICK_TONE;
    buzz_st = '0;
  endfunction

  // turning the tone on while it already sounds keeps the present frequency
  function automatic void tone_switch(logic on);
    if (on == buzz_st.tone_on) return;
    buzz_st.current_tone = on ? buzz_cfg.alarm_tone_hz : '0;
    buzz_st.tone_on = on;
  endfunction

  function automatic void alarm_stop();
    buzz_st.alarm_active     = 1'b0;
    buzz_st.alarm_start_time = '0;
    buzz_st.phase_start_time = '0;
    tone_switch(1'b0);
  endfunction

  function automatic result_t predict_buzzer(item_t beat);
    result_t res;
    logic taken;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] phase_len;
    taken = 1'b0;
    if (beat.op == OP_CLICK) begin
      // click beats read the done flag but never store it, nor advance alarm or click-end timing
      span = beat.now_ms - buzz_st.last_click_time;
      if (!buzz_st.alarm_active && !beat.countdown_done &&
          span >= TIME_W'(buzz_cfg.click_gap_ms)) begin
        buzz_st.last_click_time  = beat.now_ms;
        buzz_st.click_start_time = beat.now_ms;
        buzz_st.click_active     = 1'b1;
        buzz_st.current_tone     = buzz_cfg.click_tone_hz;
        buzz_st.tone_on          = buzz_cfg.click_tone_hz != '0;
        taken = 1'b1;
      end
    end else begin
      if (beat.countdown_done && !buzz_st.previous_done) begin
        buzz_st.click_active     = 1'b0;
        buzz_st.alarm_active     = 1'b1;
        buzz_st.alarm_start_time = beat.now_ms;
        buzz_st.phase_start_time = beat.now_ms;
        tone_switch(1'b1);
        alarm_starts++;
      end
      buzz_st.previous_done = beat.countdown_done;
      if (!beat.countdown_done && buzz_st.alarm_active) alarm_stop();
      if (buzz_st.alarm_active) begin
        span = beat.now_ms - buzz_st.alarm_start_time;
        if (span >= TIME_W'(buzz_cfg.alarm_duration_ms)) begin
          alarm_stop();
        end else begin
          phase_len = buzz_st.tone_on ? TIME_W'(buzz_cfg.beep_on_ms)
                                      : TIME_W'(buzz_cfg.beep_off_ms);
          span = beat.now_ms - buzz_st.phase_start_time;
          if (span >= phase_len) begin
            buzz_st.phase_start_time = beat.now_ms;
            tone_switch(!buzz_st.tone_on);
          end
        end
      end else if (buzz_st.click_active) begin
        span = beat.now_ms - buzz_st.click_start_time;
        if (span >= TIME_W'(buzz_cfg.click_length_ms)) begin
          buzz_st.click_active = 1'b0;
          tone_switch(1'b0);
        end
      end
    end
    res.tone_hz       = buzz_st.current_tone;
    res.alarm_running = buzz_st.alarm_active;
    res.click_running = buzz_st.click_active;
    res.request_taken = taken;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, tone_results_q.size());
      $display("alarm_and_click_buzzer_sequencer_core_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls per beat while rx_idle is set, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    beat_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        // long stretch with ready low so the block backs up into its input
        beat_out.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else if (rx_idle) begin
        stall = $urandom_range(0, MAX_IDLE);
        if (stall > 0) begin
          beat_out.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      beat_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(beat_out.valid === 1'b1 && beat_out.ready === 1'b1));
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void report_mismatch(string field, int unsigned want,
                                          int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               field, results_checked, want, got);
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && beat_out.valid === 1'b1 && beat_out.ready === 1'b1) begin
      if (tone_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = tone_results_q.pop_front();
        if (beat_out.tone_hz !== want.tone_hz)
          report_mismatch("tone_hz", want.tone_hz, beat_out.tone_hz);
        if (beat_out.alarm_running !== want.alarm_running)
          report_mismatch("alarm_running", want.alarm_running, beat_out.alarm_running);
        if (beat_out.click_running !== want.click_running)
          report_mismatch("click_running", want.click_running, beat_out.click_running);
        if (beat_out.request_taken !== want.request_taken)
          report_mismatch("request_taken", want.request_taken, beat_out.request_taken);
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender and register access
  // --------------------------------------------------------------------------
  task automatic send_beat(op_e op, logic [TIME_W-1:0] now, logic done);
    item_t beat;
    result_t want;
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      beat_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.op = op;
    beat.now_ms = now;
    beat.countdown_done = done;
    beat_in.valid          <= 1'b1;
    beat_in.op             <= op;
    beat_in.now_ms         <= now;
    beat_in.countdown_done <= done;
    @(posedge clk_i);
    while (beat_in.ready !== 1'b1) @(posedge clk_i);
    // beat accepted at this edge, valid stays up for a possible next beat
    want = predict_buzzer(beat);
    tone_results_q.push_back(want);
    beats_sent++;
    if (want.request_taken) clicks_taken++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    beat_in.valid <= 1'b0;
    do @(posedge clk_i); while (tone_results_q.size() != 0);
  endtask

  // one write per cycle; the enable is lowered by the caller's last step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_ALARM_DURATION: buzz_cfg.alarm_duration_ms = data[DUR_W-1:0];
      REG_BEEP_ON:        buzz_cfg.beep_on_ms        = data[MS_W-1:0];
      REG_BEEP_OFF:       buzz_cfg.beep_off_ms       = data[MS_W-1:0];
      REG_CLICK_LENGTH:   buzz_cfg.click_length_ms   = data[MS_W-1:0];
      REG_CLICK_GAP:      buzz_cfg.click_gap_ms      = data[MS_W-1:0];
      REG_ALARM_TONE:     buzz_cfg.alarm_tone_hz     = data[FREQ_W-1:0];
      REG_CLICK_TONE:     buzz_cfg.click_tone_hz     = data[FREQ_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // all registers, with junk in the unused upper bits of the 16-bit ones
  task automatic apply_settings(cfg_t c);
    write_reg(REG_ALARM_DURATION, c.alarm_duration_ms);
    write_reg(REG_BEEP_ON,      {8'($urandom), c.beep_on_ms});
    write_reg(REG_BEEP_OFF,     {8'($urandom), c.beep_off_ms});
    write_reg(REG_CLICK_LENGTH, {8'($urandom), c.click_length_ms});
    write_reg(REG_CLICK_GAP,    {8'($urandom), c.click_gap_ms});
    write_reg(REG_ALARM_TONE,   {8'($urandom), c.alarm_tone_hz});
    write_reg(REG_CLICK_TONE,   {8'($urandom), c.click_tone_hz});
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned typical,
                                                       logic [CFG_DATA_W-1:0] top);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return top;
    return CFG_DATA_W'($urandom_range(0, typical));
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.alarm_duration_ms = pick_value(3000, 24'hFF_FFFF);
    c.beep_on_ms        = MS_W'(pick_value(300, 24'h00_FFFF));
    c.beep_off_ms       = MS_W'(pick_value(300, 24'h00_FFFF));
    c.click_length_ms   = MS_W'(pick_value(100, 24'h00_FFFF));
    c.click_gap_ms      = MS_W'(pick_value(150, 24'h00_FFFF));
    c.alarm_tone_hz     = FREQ_W'(pick_value(65535, 24'h00_FFFF));
    c.click_tone_hz     = FREQ_W'(pick_value(65535, 24'h00_FFFF));
    return c;
  endfunction

  // well-formed traffic: time moves forward, the done flag is held for
  // stretches, clicks are mixed in; a little pure noise on top
  task automatic run_session(int unsigned beats);
    int unsigned time_scale;
    logic done;
    op_e op;
    case ($urandom_range(0, 3))
      0: time_scale = 2;
      1: time_scale = 12;
      2: time_scale = 80;
      default: time_scale = 500;
    endcase
    for (int unsigned n = 0; n < beats; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_beat(op_e'($urandom_range(0, 1)), TIME_W'($urandom),
                  1'($urandom_range(0, 1)));
      end else begin
        wall_ms = wall_ms + TIME_W'($urandom_range(0, time_scale));
        if ($urandom_range(0, 29) == 0) countdown_flag = !countdown_flag;
        op = ($urandom_range(0, 3) == 0) ? OP_CLICK : OP_UPDATE;
        done = countdown_flag;
        if (op == OP_CLICK && $urandom_range(0, 19) == 0) done = !done;
        send_beat(op, wall_ms, done);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values: click gap from time 0, click end, alarm phases, refusals,
  // alarm starting over a running click, wrap of the timestamp
  task automatic test_reset_defaults();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_beat(OP_CLICK,  32'd10,  1'b0);  // too soon after time 0
    send_beat(OP_CLICK,  32'd35,  1'b0);  // gap exactly met
    send_beat(OP_UPDATE, 32'd40,  1'b0);
    send_beat(OP_CLICK,  32'd50,  1'b0);  // too soon after last click
    send_beat(OP_UPDATE, 32'd53,  1'b0);  // click length reached
    send_beat(OP_CLICK,  32'd100, 1'b1);  // refused, flag set
    send_beat(OP_CLICK,  32'd100, 1'b0);
    send_beat(OP_UPDATE, 32'd105, 1'b1);  // alarm over click keeps click tone
    send_beat(OP_CLICK,  32'd110, 1'b0);  // refused, alarm running
    send_beat(OP_UPDATE, 32'd505, 1'b1);  // sounding phase over
    send_beat(OP_UPDATE, 32'd705, 1'b1);  // silent phase over
    send_beat(OP_UPDATE, 32'd800, 1'b0);  // flag drop ends alarm
    send_beat(OP_CLICK,  32'hFFFF_FFFF, 1'b0);
    send_beat(OP_UPDATE, 32'h0000_0011, 1'b0);  // click end across wrap
    send_beat(OP_UPDATE, 32'h0000_0020, 1'b1);
    send_beat(OP_UPDATE, 32'h0000_0020 + 32'd20000, 1'b1);  // duration over
    send_beat(OP_UPDATE, 32'h0000_0020 + 32'd20001, 1'b1);  // no restart
    send_beat(OP_UPDATE, 32'h0000_0020 + 32'd20002, 1'b0);
    drain_results();
  endtask

  // all registers at zero, then at their maxima but for zero beep phases
  task automatic test_register_extremes();
    cfg_t c;
    c = '0;
    apply_settings(c);
    send_beat(OP_UPDATE, 32'd1000, 1'b0);
    send_beat(OP_CLICK,  32'd1000, 1'b0);  // silent click, still running
    send_beat(OP_UPDATE, 32'd1000, 1'b1);  // alarm starts and stops at once
    send_beat(OP_UPDATE, 32'd1001, 1'b0);
    drain_results();
    c.alarm_duration_ms = '1;
    c.beep_on_ms        = '0;
    c.beep_off_ms       = '0;
    c.click_length_ms   = '1;
    c.click_gap_ms      = '1;
    c.alarm_tone_hz     = '1;
    c.click_tone_hz     = '1;
    apply_settings(c);
    send_beat(OP_UPDATE, 32'd2000, 1'b1);  // zero phases flip every update
    send_beat(OP_UPDATE, 32'd2001, 1'b1);
    send_beat(OP_UPDATE, 32'd2002, 1'b1);
    send_beat(OP_UPDATE, 32'd2003, 1'b0);
    send_beat(OP_CLICK,  32'd2010, 1'b0);  // maximum gap not yet met
    send_beat(OP_CLICK,  32'd1000 + 32'd65535, 1'b0);
    send_beat(OP_UPDATE, 32'd1000 + 32'd65536, 1'b0);
    drain_results();
  endtask

  // random settings per session, random idling on either side or none
  task automatic test_random_sessions();
    for (int unsigned s = 0; s < 12; s++) begin
      drain_results();
      apply_settings(random_settings());
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      wall_ms = $urandom_range(0, 1) ? TIME_W'($urandom)
                                     : 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 5000));
      run_session(90);
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    apply_settings(random_settings());
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = RX_HOLD;
    run_session(60);
    drain_results();
    rx_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= '0;
    cfg_wdata_i            <= '0;
    beat_in.valid          <= 1'b0;
    beat_in.op             <= OP_UPDATE;
    beat_in.now_ms         <= '0;
    beat_in.countdown_done <= 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 0;
    wall_ms = '0;
    countdown_flag = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    beats_sent = 0;
    results_checked = 0;
    settings_applied = 0;
    clicks_taken = 0;
    alarm_starts = 0;
    reset_predictor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_sessions();
    test_output_backpressure();

    // let any stray beat show up before the verdict
    repeat (8) @(posedge clk_i);
    $display("covered %0d beats over %0d register settings: %0d clicks taken, %0d alarms",
             beats_sent, settings_applied, clicks_taken, alarm_starts);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && tone_results_q.size() == 0) begin
      $display("alarm_and_click_buzzer_sequencer_core_tb passed");
    end else begin
      $display("alarm_and_click_buzzer_sequencer_core_tb failed");
    end
    $finish;
  end

endmodule
